// ----- design/telemetry_command_deframer_defines.svh -----
// ---------------------------------------------------------------------------
// telemetry command deframer assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_COMMAND_DEFRAMER_DEFINES_SVH
`define TELEMETRY_COMMAND_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define TCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcd assertion failed");

// checked on every edge, reset included
`define TCD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tcd assertion failed");

`else

`define TCD_ASSERT(label, clk, rst_n, prop)
`define TCD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- design/tcd_pkg.sv -----
// ---------------------------------------------------------------------------
// tcd_pkg
// shared types and constants of the telemetry command deframer
// ---------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam logic [7:0] SYNC_RESET     = 8'h24;

    localparam logic [7:0] CMD_HEARTBEAT  = 8'h0A;
    localparam logic [7:0] CMD_ARM        = 8'h0B;
    localparam logic [7:0] CMD_FLIGHT     = 8'h0C;
    localparam logic [7:0] CMD_TEST       = 8'h0D;
    localparam logic [7:0] CMD_DISARM     = 8'h0E;

    localparam logic [7:0] TEST_MAX_ARGS  = 8'd6;
    localparam logic [3:0] TEST_HDR_LEFT  = 4'd8;
    localparam logic [3:0] TEST_CNT_LEFT  = 4'd6;
    localparam logic [3:0] HB_LEFT        = 4'd1;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_SYNC_MISS   = 3'd1;
    localparam logic [2:0] EV_BAD_CMD     = 3'd2;
    localparam logic [2:0] EV_ARM         = 3'd3;
    localparam logic [2:0] EV_FLIGHT      = 3'd4;
    localparam logic [2:0] EV_DISARM      = 3'd5;
    localparam logic [2:0] EV_HEARTBEAT   = 3'd6;
    localparam logic [2:0] EV_TEST        = 3'd7;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_xfer;

endpackage

`default_nettype wire

// ----- design/tcd_in_stage.sv -----
// ---------------------------------------------------------------------------
// tcd_in_stage
// input register: holds one received byte until the deframer takes it
// ---------------------------------------------------------------------------
`default_nettype none

module tcd_in_stage
    import tcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output t_byte_xfer      o_xfer,
    input  wire logic       i_ready
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_stall = r_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_xfer.valid = r_valid;
    assign o_xfer.data  = r_data;

endmodule

`default_nettype wire

// ----- design/tcd_deframe.sv -----
// ---------------------------------------------------------------------------
// tcd_deframe
// packet state machine, argument store and result register
// ---------------------------------------------------------------------------
`default_nettype none

module tcd_deframe
    import tcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_sync,
    input  wire t_byte_xfer i_xfer,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_event_res,
    output logic [63:0]     o_arg_bytes
);

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_CODE,
        PH_ARGS
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HB,
        KIND_TEST
    } t_kind;

    t_phase          r_phase, n_phase;
    t_kind           r_kind, n_kind;
    logic [3:0]      r_left, n_left;
    logic [7:0][7:0] r_store, n_store;
    logic [2:0]      r_event, n_event;
    logic            r_valid;
    logic [3:0]      left_dec;
    logic            advance;
    logic [7:0]      b;

    assign o_ready = !r_valid || !i_stall;
    assign advance = i_xfer.valid && o_ready;
    assign b       = i_xfer.data;
    assign left_dec = r_left - 4'd1;

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_left  = r_left;
        n_store = r_store;
        n_event = EV_NONE;
        case (r_phase)
            PH_SYNC: begin
                if (b != i_sync) begin
                    n_event = EV_SYNC_MISS;
                end else begin
                    n_phase = PH_CODE;
                end
            end
            PH_CODE: begin
                n_phase = PH_SYNC;
                n_kind  = KIND_NONE;
                n_left  = '0;
                case (b)
                    CMD_HEARTBEAT: begin
                        n_phase = PH_ARGS;
                        n_kind  = KIND_HB;
                        n_left  = HB_LEFT;
                    end
                    CMD_TEST: begin
                        n_phase = PH_ARGS;
                        n_kind  = KIND_TEST;
                        n_left  = TEST_HDR_LEFT;
                    end
                    CMD_ARM:    n_event = EV_ARM;
                    CMD_FLIGHT: n_event = EV_FLIGHT;
                    CMD_DISARM: n_event = EV_DISARM;
                    default:    n_event = EV_BAD_CMD;
                endcase
            end
            PH_ARGS: begin
                if (r_left != 4'd0 && (r_kind == KIND_HB || r_kind == KIND_TEST)) begin
                    n_store[left_dec[2:0]] = b;
                    n_left = left_dec;
                    if (r_kind == KIND_HB) begin
                        n_event = EV_HEARTBEAT;
                    end else begin
                        // count byte, saturated so the store is never overrun
                        if (left_dec == TEST_CNT_LEFT) begin
                            n_left = (b > TEST_MAX_ARGS) ? TEST_MAX_ARGS[3:0] : b[3:0];
                        end
                        if (n_left == 4'd0) begin
                            n_event = EV_TEST;
                        end
                    end
                    if (n_left == 4'd0) begin
                        n_phase = PH_SYNC;
                        n_kind  = KIND_NONE;
                    end
                end else begin
                    n_phase = PH_SYNC;
                    n_kind  = KIND_NONE;
                    n_left  = '0;
                end
            end
            default: begin
                n_phase = PH_SYNC;
                n_kind  = KIND_NONE;
                n_left  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_kind  <= KIND_NONE;
            r_left  <= '0;
            r_store <= '0;
            r_valid <= 1'b0;
            r_event <= EV_NONE;
        end else begin
            if (o_ready) begin
                r_valid <= i_xfer.valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_left  <= n_left;
                r_store <= n_store;
                r_event <= n_event;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_event_res = r_event;
    assign o_arg_bytes = r_store;

endmodule

`default_nettype wire

// ----- design/telemetry_command_deframer.sv -----
// ---------------------------------------------------------------------------
// telemetry_command_deframer
// deframes sync/command/argument packets from a received byte stream
// ---------------------------------------------------------------------------
// One byte is taken per clock when the output is not stalled, and every byte
// gives one result (event code and the packed 8-byte argument store) after
// passing the input register and then the packet state update into the
// result register. The state update is the only loop, so the sustained rate
// is one byte per cycle while the output is not stalled.
// r_sync resets to 0x24 and is written through i_cfg_we/i_cfg_wdata.
// ---------------------------------------------------------------------------
`default_nettype none

`include "telemetry_command_deframer_defines.svh"

module telemetry_command_deframer
    import tcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_res,
    output logic [63:0]      o_arg_bytes
);

    logic [7:0] r_sync;
    t_byte_xfer stage_xfer;
    logic       deframe_ready;
    logic       advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_wdata;
        end
    end

    tcd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .o_xfer    (stage_xfer),
        .i_ready   (deframe_ready)
    );

    tcd_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync      (r_sync),
        .i_xfer      (stage_xfer),
        .o_ready     (deframe_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_event_res (o_event_res),
        .o_arg_bytes (o_arg_bytes)
    );

    assign advance = stage_xfer.valid && deframe_ready;

    `TCD_ASSERT(a_adv_gives_result, i_clk, i_rst_n, advance |=> o_valid)
    `TCD_ASSERT(a_store_holds, i_clk, i_rst_n, !advance |=> $stable(o_arg_bytes))
    `TCD_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_stall |-> stage_xfer.valid)
    `TCD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// telemetry command deframer testbench
// drives byte transfers with random gaps and output stall, tracks packet
// state alongside the block and checks every event code and argument store
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcd_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  ev;
        logic [63:0] args;
    } t_deframe_result;

    typedef enum logic [1:0] {
        WAIT_SYNC,
        WAIT_CODE,
        WAIT_ARGS
    } t_deframe_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HEARTBEAT,
        KIND_TEST
    } t_packet_kind;

    class packet_tracker;
        logic [7:0]      sync_byte;
        t_deframe_phase  phase;
        t_packet_kind    kind;
        logic [3:0]      bytes_left;
        logic [7:0]      arg_store [8];
        t_deframe_result expected_events [$];
        int              mismatches;

        function new();
            sync_byte = SYNC_RESET;
            phase = WAIT_SYNC;
            kind = KIND_NONE;
            bytes_left = 4'd0;
            foreach (arg_store[i]) arg_store[i] = 8'h00;
            mismatches = 0;
        endfunction

        function void set_sync(logic [7:0] value);
            sync_byte = value;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void go_idle();
            phase = WAIT_SYNC;
            kind = KIND_NONE;
            bytes_left = 4'd0;
        endfunction

        function void note_byte(logic [7:0] b);
            t_deframe_result res;
            res.ev = EV_NONE;
            case (phase)
                WAIT_SYNC: begin
                    if (b != sync_byte) begin
                        res.ev = EV_SYNC_MISS;
                        go_idle();
                    end else begin
                        phase = WAIT_CODE;
                    end
                end
                WAIT_CODE: begin
                    case (b)
                        CMD_HEARTBEAT: begin
                            kind = KIND_HEARTBEAT;
                            bytes_left = HB_LEFT;
                            phase = WAIT_ARGS;
                        end
                        CMD_TEST: begin
                            kind = KIND_TEST;
                            bytes_left = TEST_HDR_LEFT;
                            phase = WAIT_ARGS;
                        end
                        CMD_ARM: begin
                            res.ev = EV_ARM;
                            go_idle();
                        end
                        CMD_FLIGHT: begin
                            res.ev = EV_FLIGHT;
                            go_idle();
                        end
                        CMD_DISARM: begin
                            res.ev = EV_DISARM;
                            go_idle();
                        end
                        default: begin
                            res.ev = EV_BAD_CMD;
                            go_idle();
                        end
                    endcase
                end
                WAIT_ARGS: begin
                    if (bytes_left != 4'd0 && kind != KIND_NONE) begin
                        bytes_left = bytes_left - 4'd1;
                        arg_store[bytes_left[2:0]] = b;
                        if (kind == KIND_HEARTBEAT) begin
                            res.ev = EV_HEARTBEAT;
                        end else begin
                            // count byte just landed, saturate it
                            if (bytes_left == TEST_CNT_LEFT) begin
                                if (arg_store[6] > TEST_MAX_ARGS)
                                    bytes_left = TEST_MAX_ARGS[3:0];
                                else
                                    bytes_left = arg_store[6][3:0];
                            end
                            if (bytes_left == 4'd0)
                                res.ev = EV_TEST;
                        end
                        if (bytes_left == 4'd0)
                            go_idle();
                    end else begin
                        go_idle();
                    end
                end
                default: go_idle();
            endcase
            for (int i = 0; i < 8; i++)
                res.args[8*i +: 8] = arg_store[i];
            expected_events.push_back(res);
        endfunction

        function void check_result(logic [2:0] ev, logic [63:0] args);
            t_deframe_result exp_res;
            if (expected_events.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: event %0d args %h", ev, args);
                mismatches++;
                return;
            end
            exp_res = expected_events.pop_front();
            if (ev !== exp_res.ev || args !== exp_res.args) begin
                if (mismatches < 10)
                    $display("mismatch: event exp %0d got %0d, args exp %h got %h",
                             exp_res.ev, ev, exp_res.args, args);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_event_res;
    logic [63:0] o_arg_bytes;

    packet_tracker tracker = new();
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;
    int            bytes_sent = 0;
    int            cycle_count = 0;

    telemetry_command_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_event_res (o_event_res),
        .o_arg_bytes (o_arg_bytes)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check, then pick next stall
    initial begin
        int hold_left;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                tracker.check_result(o_event_res, o_arg_bytes);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 24);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_sync(value);
    endtask

    task automatic send_packet(input logic [7:0] sync_byte);
        int         pick;
        int         code_sel;
        logic [7:0] cnt;
        int         nargs;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        send_byte(sync_byte);
        // truncated packet, the next sync lands in the wrong place
        if (pick < 14)
            return;
        code_sel = $urandom_range(9);
        case (code_sel)
            0, 8: begin
                send_byte(CMD_HEARTBEAT);
                send_byte(8'($urandom_range(255)));
            end
            1: send_byte(CMD_ARM);
            2: send_byte(CMD_FLIGHT);
            3: send_byte(CMD_DISARM);
            7: send_byte(8'($urandom_range(255)));
            default: begin
                send_byte(CMD_TEST);
                send_byte(8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    cnt = 8'($urandom_range(255));
                else
                    cnt = 8'($urandom_range(6));
                send_byte(cnt);
                nargs = int'((cnt > TEST_MAX_ARGS) ? TEST_MAX_ARGS : cnt);
                repeat (nargs) send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic run_random(input logic [7:0] sync_byte, input int n_bytes,
                              input bit with_hold);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if (with_hold && bytes_sent - start >= 100) begin
                hold_req = 1'b1;
                with_hold = 1'b0;
            end
            send_packet(sync_byte);
        end
    endtask

    initial begin
        logic [7:0] directed_bytes [$];
        logic [7:0] rand_sync;
        directed_bytes = '{
            8'hFF,
            SYNC_RESET, CMD_ARM,
            SYNC_RESET, CMD_FLIGHT,
            SYNC_RESET, CMD_DISARM,
            SYNC_RESET, 8'h00,
            SYNC_RESET, CMD_HEARTBEAT, 8'h81,
            SYNC_RESET, CMD_TEST, 8'h7E, 8'h00,
            SYNC_RESET, CMD_TEST, 8'h33, 8'hFF,
            8'hAA, 8'h55, 8'hFF, 8'h00, 8'h01, 8'h80
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        write_sync(8'h00);
        quiet = 1'b1;
        run_random(8'h00, 400, 1'b0);
        quiet = 1'b0;

        write_sync(8'hFF);
        run_random(8'hFF, 400, 1'b1);

        rand_sync = 8'($urandom_range(255));
        write_sync(rand_sync);
        run_random(rand_sync, 400, 1'b0);

        write_sync(SYNC_RESET);
        run_random(SYNC_RESET, 400, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0)
            $display("%0d expected results never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
